[design/lers_pkg.sv]
package lers_pkg;

  // lattice geometry
  localparam int SITES = 128;
  localparam int IDX_W = 7;
  localparam logic [IDX_W:0] SITES_W = (IDX_W + 1)'(SITES);
  localparam logic [IDX_W-1:0] LAST_SITE = IDX_W'(SITES - 1);

  // gather tree shape
  localparam int GROUP = 8;
  localparam int GROUPS = (SITES + GROUP - 1) / GROUP;

  // opcodes
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_RESTART = 2'd1;
  localparam logic [1:0] OP_MOVE    = 2'd2;

  // site contents
  localparam logic [1:0] SV_EMPTY  = 2'd0;
  localparam logic [1:0] SV_NORMAL = 2'd1;
  localparam logic [1:0] SV_RESET  = 2'd2;
  localparam logic [1:0] SV_UNUSED = 2'd3;

  // event codes
  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_INJECT = 3'd1;
  localparam logic [2:0] EV_REMOVE = 3'd2;
  localparam logic [2:0] EV_HOP_R  = 3'd3;
  localparam logic [2:0] EV_HOP_L  = 3'd4;
  localparam logic [2:0] EV_JUMP   = 3'd5;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND = 1'b1;

  // threshold reset values
  localparam logic [31:0] FIRST_THR_RST  = 32'd1771120534;
  localparam logic [31:0] SECOND_THR_RST = 32'd3542241068;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [6:0]  site_index;
    logic [1:0]  site_value;
    logic [31:0] random_fraction;
  } lers_in_t;

  typedef struct packed {
    logic [2:0] event_kind;
    logic [6:0] reset_position;
  } lers_out_t;

  // update broadcast to every cell
  typedef enum logic [2:0] {
    UPD_NONE,
    UPD_LOAD,
    UPD_RESTART,
    UPD_INJECT,
    UPD_REMOVE,
    UPD_HOP_R,
    UPD_HOP_L,
    UPD_JUMP
  } lers_upd_e;

  typedef struct packed {
    lers_upd_e        kind;
    logic [IDX_W-1:0] site;
    logic [IDX_W-1:0] target;
    logic [1:0]       value;
  } lers_upd_t;

  // neighborhood query of a move attempt
  typedef struct packed {
    logic [IDX_W-1:0] site;
    logic [IDX_W-1:0] plus;
    logic [IDX_W-1:0] minus;
    logic [IDX_W-1:0] home;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
  } lers_qry_t;

  // per-cell answer, or-combined over the lattice
  typedef struct packed {
    logic [1:0] a_val;
    logic       right_occ;
    logic       left_occ;
    logic       home_occ;
    logic       span_occ;
  } lers_flags_t;

  localparam int FLAG_W = $bits(lers_flags_t);

endpackage

[design/lers_cell.sv]
module lers_cell
  import lers_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] cell_idx_i,
  input  logic [1:0]       left_i,
  input  logic [1:0]       right_i,
  input  lers_upd_t        upd_i,
  input  lers_qry_t        qry_i,
  output logic [1:0]       val_o,
  output lers_flags_t      leaf_o
);

  logic [1:0] val_q, val_d;
  logic [1:0] init_q, init_d;
  logic       hit_site, hit_target, occ;

  assign hit_site   = (cell_idx_i == upd_i.site);
  assign hit_target = (cell_idx_i == upd_i.target);
  assign occ        = (val_q != SV_EMPTY);

  // local update from the broadcast command and the neighbors
  always_comb begin
    val_d  = val_q;
    init_d = init_q;
    case (upd_i.kind)
      UPD_LOAD: begin
        if (hit_site) begin
          val_d  = upd_i.value;
          init_d = upd_i.value;
        end else if (upd_i.value == SV_RESET) begin
          // only one reset particle may exist
          if (val_q == SV_RESET) val_d = SV_EMPTY;
          if (init_q == SV_RESET) init_d = SV_EMPTY;
        end
      end
      UPD_RESTART: val_d = init_q;
      UPD_INJECT:  if (hit_site) val_d = SV_NORMAL;
      UPD_REMOVE:  if (hit_site) val_d = SV_EMPTY;
      UPD_HOP_R: begin
        if (hit_site) val_d = SV_EMPTY;
        else if (hit_target) val_d = left_i;
      end
      UPD_HOP_L: begin
        if (hit_site) val_d = SV_EMPTY;
        else if (hit_target) val_d = right_i;
      end
      UPD_JUMP: begin
        if (hit_site) val_d = SV_EMPTY;
        else if (hit_target) val_d = SV_RESET;
      end
      default: begin
        val_d  = val_q;
        init_d = init_q;
      end
    endcase
  end

  // site contents
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q  <= SV_EMPTY;
      init_q <= SV_EMPTY;
    end else begin
      val_q  <= val_d;
      init_q <= init_d;
    end
  end

  // this cell's share of the neighborhood query
  always_comb begin
    leaf_o.a_val     = (cell_idx_i == qry_i.site) ? val_q : SV_EMPTY;
    leaf_o.right_occ = occ && (cell_idx_i == qry_i.plus);
    leaf_o.left_occ  = occ && (cell_idx_i == qry_i.minus);
    leaf_o.home_occ  = occ && (cell_idx_i == qry_i.home);
    leaf_o.span_occ  = occ && (cell_idx_i > qry_i.lo) && (cell_idx_i < qry_i.hi);
  end

  assign val_o = val_q;

endmodule

[design/lers_gather.sv]
module lers_gather
  import lers_pkg::*;
(
  input  logic        clk_i,
  input  lers_flags_t leaf_i [SITES],
  output lers_flags_t sum_o
);

  logic [FLAG_W-1:0] grp_d [GROUPS];
  logic [FLAG_W-1:0] grp_q [GROUPS];
  logic [FLAG_W-1:0] sum_d, sum_q;

  // first level: or over groups of eight cells
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < SITES) grp_d[g] = grp_d[g] | leaf_i[g * GROUP + k];
      end
    end
  end

  // second level: or over the groups
  always_comb begin
    sum_d = '0;
    for (int g = 0; g < GROUPS; g++) begin
      sum_d = sum_d | grp_q[g];
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
    sum_q <= sum_d;
  end

  assign sum_o = lers_flags_t'(sum_q);

endmodule

[design/lattice_exclusion_reset_step_core.sv]
// channel   | handshake                  | payload
// ----------+----------------------------+--------------------------------
// command   | start / busy               | item_i (lers_in_t)
// result    | done_o strobe, one cycle   | result_o (lers_out_t)
// config    | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// load, restart and no-op items: result the cycle after start.
// a move attempt holds busy through the leaf, group and decide states: query broadcast to the cells, two
// registered levels of the or-gather tree, then decide and commit; result next.
// reset empties both lattice copies, home and reset site go to zero.
// the receiver cannot stall; configuration is always ready.
module lattice_exclusion_reset_step_core
  import lers_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  lers_in_t             item_i,
  output logic                 done_o,
  output lers_out_t            result_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEAF,
    ST_GROUP,
    ST_DECIDE
  } st_e;

  st_e              st_q, st_d;
  logic             done_q, done_d;
  lers_out_t        res_q, res_d;
  lers_qry_t        qry_q, qry_d;
  logic             ba_q, ba_d, bb_q, bb_d, bc_q, bc_d;
  logic [31:0]      thr1_q, thr2_q;
  logic [IDX_W-1:0] home_q, home_d, rs_q, rs_d;
  logic             lp_q, lp_d, ip_q, ip_d;
  lers_upd_t        upd;
  logic [2:0]       ev;
  logic             accept, a_ok, is_first, is_last, jump_ok;
  logic [IDX_W-1:0] a;
  logic [31:0]      r;
  logic [1:0]       c;
  lers_flags_t      sum;
  logic [1:0]       val  [SITES];
  lers_flags_t      leaf [SITES];

  assign busy        = (st_q != ST_IDLE);
  assign accept      = start && !busy;
  assign a           = item_i.site_index;
  assign r           = item_i.random_fraction;
  assign a_ok        = ({1'b0, a} < SITES_W);
  assign cfg_ready_o = 1'b1;

  // row of site cells, each seeing its two neighbors
  for (genvar i = 0; i < SITES; i++) begin : g_cell
    logic [1:0] left_v, right_v;
    if (i == 0) begin : g_lend
      assign left_v = SV_EMPTY;
    end else begin : g_lmid
      assign left_v = val[i-1];
    end
    if (i == SITES - 1) begin : g_rend
      assign right_v = SV_EMPTY;
    end else begin : g_rmid
      assign right_v = val[i+1];
    end
    lers_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IDX_W'(i)),
      .left_i     (left_v),
      .right_i    (right_v),
      .upd_i      (upd),
      .qry_i      (qry_q),
      .val_o      (val[i]),
      .leaf_o     (leaf[i])
    );
  end

  lers_gather u_gather (
    .clk_i  (clk_i),
    .leaf_i (leaf),
    .sum_o  (sum)
  );

  assign c        = sum.a_val;
  assign is_first = (qry_q.site == '0);
  assign is_last  = (qry_q.site == LAST_SITE);
  assign jump_ok  = !sum.home_occ && !sum.span_occ;

  // control and next state
  always_comb begin
    st_d         = st_q;
    done_d       = 1'b0;
    res_d        = res_q;
    qry_d        = qry_q;
    ba_d         = ba_q;
    bb_d         = bb_q;
    bc_d         = bc_q;
    home_d       = home_q;
    rs_d         = rs_q;
    lp_d         = lp_q;
    ip_d         = ip_q;
    ev           = EV_NONE;
    upd.kind     = UPD_NONE;
    upd.site     = a;
    upd.target   = a;
    upd.value    = item_i.site_value;
    unique case (st_q)
      ST_IDLE: begin
        if (accept) begin
          done_d = 1'b1;
          unique case (item_i.opcode)
            OP_LOAD: begin
              if (a_ok && item_i.site_value != SV_UNUSED) begin
                upd.kind = UPD_LOAD;
                if (item_i.site_value == SV_RESET) begin
                  home_d = a;
                  rs_d   = a;
                  lp_d   = 1'b1;
                  ip_d   = 1'b1;
                end else begin
                  if (a == rs_q) lp_d = 1'b0;
                  if (a == home_q) ip_d = 1'b0;
                end
              end
            end
            OP_RESTART: begin
              upd.kind = UPD_RESTART;
              rs_d     = home_q;
              lp_d     = ip_q;
            end
            OP_MOVE: begin
              if (a_ok) begin
                done_d      = 1'b0;
                st_d        = ST_LEAF;
                qry_d.site  = a;
                qry_d.plus  = a + IDX_W'(1);
                qry_d.minus = a - IDX_W'(1);
                qry_d.home  = home_q;
                qry_d.lo    = (a < home_q) ? a : home_q;
                qry_d.hi    = (a < home_q) ? home_q : a;
                ba_d        = (r != '0) && (r < thr1_q);
                bb_d        = (r > thr1_q) && (r < thr2_q);
                bc_d        = (r > thr2_q);
              end
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      ST_LEAF:  st_d = ST_GROUP;
      ST_GROUP: st_d = ST_DECIDE;
      ST_DECIDE: begin
        st_d   = ST_IDLE;
        done_d = 1'b1;
        // end sites inject and remove, all sites hop or jump
        if (is_first) begin
          if (c == SV_EMPTY) begin
            if (ba_q) upd.kind = UPD_INJECT;
          end else if (c == SV_NORMAL) begin
            if (bb_q) upd.kind = UPD_REMOVE;
            else if (ba_q && !sum.right_occ) upd.kind = UPD_HOP_R;
          end else if (c == SV_RESET && bc_q && jump_ok) begin
            upd.kind = UPD_JUMP;
          end
        end else if (is_last) begin
          if (c == SV_EMPTY) begin
            if (bb_q) upd.kind = UPD_INJECT;
          end else if (c == SV_NORMAL) begin
            if (ba_q) upd.kind = UPD_REMOVE;
            else if (bb_q && !sum.left_occ) upd.kind = UPD_HOP_L;
          end else if (c == SV_RESET && bc_q && jump_ok) begin
            upd.kind = UPD_JUMP;
          end
        end else if (c != SV_EMPTY) begin
          if (ba_q) begin
            if (!sum.right_occ) upd.kind = UPD_HOP_R;
          end else if (bb_q) begin
            if (!sum.left_occ) upd.kind = UPD_HOP_L;
          end else if (bc_q && c == SV_RESET && jump_ok) begin
            upd.kind = UPD_JUMP;
          end
        end
        upd.site = qry_q.site;
        case (upd.kind)
          UPD_INJECT: ev = EV_INJECT;
          UPD_REMOVE: ev = EV_REMOVE;
          UPD_HOP_R: begin
            ev         = EV_HOP_R;
            upd.target = qry_q.plus;
          end
          UPD_HOP_L: begin
            ev         = EV_HOP_L;
            upd.target = qry_q.minus;
          end
          UPD_JUMP: begin
            ev         = EV_JUMP;
            upd.target = qry_q.home;
          end
          default: ev = EV_NONE;
        endcase
        // reset particle follows its move
        if (c == SV_RESET && (upd.kind == UPD_HOP_R || upd.kind == UPD_HOP_L ||
                              upd.kind == UPD_JUMP)) begin
          rs_d = upd.target;
        end
      end
      default: st_d = ST_IDLE;
    endcase
    if (done_d) begin
      res_d.event_kind     = ev;
      res_d.reset_position = lp_d ? rs_d : '0;
    end
  end

  // state machine and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      done_q <= 1'b0;
      res_q  <= '0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
      res_q  <= res_d;
    end
  end

  // move attempt command
  always_ff @(posedge clk_i) begin
    qry_q <= qry_d;
    ba_q  <= ba_d;
    bb_q  <= bb_d;
    bc_q  <= bc_d;
  end

  // reset particle bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      home_q <= '0;
      rs_q   <= '0;
      lp_q   <= 1'b0;
      ip_q   <= 1'b0;
    end else begin
      home_q <= home_d;
      rs_q   <= rs_d;
      lp_q   <= lp_d;
      ip_q   <= ip_d;
    end
  end

  // threshold registers, written on a config transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr1_q <= FIRST_THR_RST;
      thr2_q <= SECOND_THR_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_FIRST:  thr1_q <= cfg_data_i;
        CFG_SECOND: thr2_q <= cfg_data_i;
        default:    thr1_q <= thr1_q;
      endcase
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

[design/lers_checker.sv]
module lers_checker
  import lers_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input lers_in_t             item_i,
  input logic                 done_o,
  input lers_out_t            result_o
);

  // a result never shows while a move is still at work
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result strobe while busy");

  // every accepted item either answers next cycle or goes busy
  a_accept_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (done_o || busy)) else $error("accepted item lost");

  // checks how long a move attempt holds busy once it rises
  a_busy_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> ##1 busy ##1 busy ##1 !busy) else $error("busy length wrong");

  // busy drops only together with the result strobe
  a_busy_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o) else $error("move ended without result");

  // anything but a move reports no event
  a_nonmove_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.opcode != OP_MOVE) |=>
      (done_o && result_o.event_kind == EV_NONE)) else $error("event on non-move item");

endmodule

bind lattice_exclusion_reset_step_core lers_checker u_lers_checker (.*);
